FILE: hw/rtl/tfcm_pkg.sv
package tfcm_pkg;

    // Fixed field widths
    localparam int TEMP_W  = 14;
    localparam int SCALE_W = 20;
    localparam int COORD_W = 8;
    localparam int CHAN_W  = 8;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    // Palette geometry
    localparam int PALETTE_ENTRIES = 7;
    localparam int FRACTION_BITS   = 8;
    localparam int BASE_COLOURS    = 7;
    localparam int IDX_W = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1;

    // Datapath widths: the offset magnitude fits TEMP_W bits unsigned
    localparam int SCALE_SHIFT = 16;
    localparam int DIFF_W      = TEMP_W;
    localparam int PROD_W      = DIFF_W + SCALE_W;
    localparam int POS_W       = PROD_W - SCALE_SHIFT;
    localparam logic [POS_W-1:0] TOP_POS =
        POS_W'(PALETTE_ENTRIES - 1) << FRACTION_BITS;

    // Register reset values
    localparam logic signed [TEMP_W-1:0] LOW_TEMP_RESET       = 14'sd80;
    localparam logic [SCALE_W-1:0]       POSITION_SCALE_RESET = 20'd139810;

    // Register map
    typedef enum logic [0:0] {
        REG_LOW_TEMP       = 1'b0,
        REG_POSITION_SCALE = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic [COORD_W-1:0]       pixel_row;
        logic [COORD_W-1:0]       pixel_col;
    } pixel_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_row;
        logic [COORD_W-1:0] out_col;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
    } color_t;

    // Palette entry as {red, green, blue}; indexes past the table repeat white
    function automatic logic [2:0] palette_rgb(input logic [IDX_W-1:0] idx);
        logic [2:0] rgb;
        case (int'(idx))
            0:       rgb = 3'b000;
            1:       rgb = 3'b001;
            2:       rgb = 3'b010;
            3:       rgb = 3'b110;
            4:       rgb = 3'b100;
            5:       rgb = 3'b101;
            default: rgb = 3'b111;
        endcase
        return rgb;
    endfunction

    // ((c1 << F) + (c2 - c1) * frac) * 255 >> F, with the x255 as shift-subtract
    function automatic logic [CHAN_W-1:0] blend(input logic c1, input logic c2,
                                                input logic [FRACTION_BITS-1:0] frac);
        logic [FRACTION_BITS:0]   mix;
        logic [FRACTION_BITS+8:0] scaled;
        logic [FRACTION_BITS+8:0] mix_ext;
        if (c1 == c2)
            mix = c1 ? ((FRACTION_BITS+1)'(1) << FRACTION_BITS) : '0;
        else if (c2)
            mix = {1'b0, frac};
        else
            mix = ((FRACTION_BITS+1)'(1) << FRACTION_BITS) - {1'b0, frac};
        mix_ext = {8'b0, mix};
        scaled  = (mix_ext << 8) - mix_ext;
        return scaled[FRACTION_BITS+7:FRACTION_BITS];
    endfunction

endpackage

FILE: hw/rtl/thermal_false_colour_map_top.sv
// Thermal false-color mapper. Each pixel beat carries a signed temperature in
// 1/16 degC plus its row and column; each color beat carries the same
// coordinates with an 8-bit red, green and blue value. The block subtracts
// low_temp, multiplies by position_scale (Q16) to get a palette position in
// 1/256 steps and blends between adjacent entries of a seven-color palette
// (black, blue, green, yellow, red, magenta, white); at or below low_temp the
// pixel is black, past the top it is white. Throughput is one pixel per clock
// unless color_ready stalls the output; each pixel passes three register stages
// (offset, multiply, blend), a stage loading when empty or its beat moves on,
// so beats hold under back-pressure, none dropped or repeated. The user writes
// low_temp (address 0, signed) and position_scale (address 4) over the APB port
// only while no pixel is in flight, unchecked by the block; pready is tied high.
module thermal_false_colour_map_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pixel_valid,
    output logic                              pixel_ready,
    input  tfcm_pkg::pixel_t                  pixel,
    output logic                              color_valid,
    input  logic                              color_ready,
    output tfcm_pkg::color_t                  color,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tfcm_pkg::APB_AW-1:0]       paddr,
    input  logic [tfcm_pkg::APB_DW-1:0]       pwdata,
    output logic [tfcm_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);
    import tfcm_pkg::*;

    // Configuration registers
    logic signed [TEMP_W-1:0] low_temp_reg;
    logic [SCALE_W-1:0]       position_scale_reg;
    reg_index_t               reg_sel;
    logic                     cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[2]);
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_temp_reg       <= LOW_TEMP_RESET;
            position_scale_reg <= POSITION_SCALE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_LOW_TEMP:       low_temp_reg       <= pwdata[TEMP_W-1:0];
                REG_POSITION_SCALE: position_scale_reg <= pwdata[SCALE_W-1:0];
                default:            ;
            endcase
        end
    end

    // Read back low_temp sign-extended, position_scale zero-extended
    always_comb
    begin
        unique case (reg_sel)
            REG_LOW_TEMP:
                prdata = {{(APB_DW-TEMP_W){low_temp_reg[TEMP_W-1]}}, low_temp_reg};
            REG_POSITION_SCALE:
                prdata = {{(APB_DW-SCALE_W){1'b0}}, position_scale_reg};
            default:
                prdata = '0;
        endcase
    end

    // Pipeline control: a stage loads when it is empty or its beat moves on
    logic v1_reg, v2_reg, v3_reg;
    logic load1, load2, load3;

    assign load3       = !v3_reg || color_ready;
    assign load2       = !v2_reg || load3;
    assign load1       = !v1_reg || load2;
    assign pixel_ready = load1;
    assign color_valid = v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (load1)
                v1_reg <= pixel_valid;
            if (load2)
                v2_reg <= v1_reg;
            if (load3)
                v3_reg <= v2_reg;
        end
    end

    // Stage 1: offset from low_temp, clamped at zero
    logic signed [TEMP_W:0]   diff;
    logic [DIFF_W-1:0]        diff_next;
    logic [DIFF_W-1:0]        diff_reg;
    logic [COORD_W-1:0]       row1_reg, col1_reg;

    assign diff      = $signed({pixel.temperature[TEMP_W-1], pixel.temperature})
                     - $signed({low_temp_reg[TEMP_W-1], low_temp_reg});
    assign diff_next = (diff > 0) ? diff[DIFF_W-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            diff_reg <= diff_next;
            row1_reg <= pixel.pixel_row;
            col1_reg <= pixel.pixel_col;
        end
    end

    // Stage 2: scale into palette position
    logic [PROD_W-1:0] prod;
    logic [POS_W-1:0]  pos_reg;
    logic [COORD_W-1:0] row2_reg, col2_reg;

    assign prod = {{SCALE_W{1'b0}}, diff_reg} * {{DIFF_W{1'b0}}, position_scale_reg};

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            pos_reg  <= prod[PROD_W-1:SCALE_SHIFT];
            row2_reg <= row1_reg;
            col2_reg <= col1_reg;
        end
    end

    // Stage 3: pick the palette pair and blend each channel
    logic [IDX_W-1:0]         i1, i2;
    logic [FRACTION_BITS-1:0] frac;
    logic [2:0]               rgb1, rgb2;
    color_t                   color_next;
    color_t                   color_reg;

    always_comb
    begin
        if (pos_reg >= TOP_POS)
        begin
            i1   = IDX_W'(PALETTE_ENTRIES - 1);
            i2   = IDX_W'(PALETTE_ENTRIES - 1);
            frac = '0;
        end
        else
        begin
            i1   = pos_reg[IDX_W+FRACTION_BITS-1:FRACTION_BITS];
            i2   = i1 + IDX_W'(1);
            frac = pos_reg[FRACTION_BITS-1:0];
        end
        rgb1 = palette_rgb(i1);
        rgb2 = palette_rgb(i2);
        color_next.out_row = row2_reg;
        color_next.out_col = col2_reg;
        color_next.red     = blend(rgb1[2], rgb2[2], frac);
        color_next.green   = blend(rgb1[1], rgb2[1], frac);
        color_next.blue    = blend(rgb1[0], rgb2[0], frac);
    end

    always_ff @(posedge clk)
    begin
        if (load3)
            color_reg <= color_next;
    end

    assign color = color_reg;

endmodule
